[rtl/core/hrsl_pkg.sv]
package hrsl_pkg;

   localparam logic [31:0] MIX_MULT  = 32'h045d_9f3b;
   localparam int unsigned MIX_SHIFT = 16;

   // label mod 100000 = ((label >> 5) mod 3125) * 32 + (label & 31)
   localparam int unsigned ID_LOW_BITS = 5;
   localparam logic [31:0] ID_DIVISOR  = 32'd3125;
   // floor(2^32 / 3125): quotient estimate is low by at most one
   localparam logic [31:0] ID_RECIP    = 32'd1374389;

   localparam int unsigned CFG_WIDTH = 9;
   localparam int unsigned POS_WIDTH = 8;
   localparam int unsigned SID_WIDTH = 17;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   function automatic logic [31:0] xor_shift(input logic [31:0] x);
      xor_shift = x ^ (x >> MIX_SHIFT);
   endfunction

endpackage

[rtl/core/hash_ring_successor_lookup.sv]
// Consistent-hashing ring with successor lookup.
// req channel: tuser is the command (0 writes a ring entry, 1 looks up a key hash);
// tdata carries entry_index, entry_label and key_hash. Every transaction on req
// yields exactly one transaction on rsp: a write acknowledge echoing the index, or
// the successor position and its server id (label mod 100000) for a lookup.
// csr_wen/csr_wdata set entries_in_use; write it only while the block is idle.
// A write moves the sequencer to ST_DONE, which loads the rsp register once it is free.
// A lookup binary-searches the ring with one memory read port and one shared 32x32
// multiplier: each probe steps through read, two mix multiplies, compare and next
// step. The first probe is entry 0; when the key is at or below its hash, the
// search ends there and entry 0 is the successor.
// The block handles one transaction at a time; req_tready is low while it works.
// A finished result sits in the rsp register; the block may take the next request
// while it waits, but stalls before producing another result until rsp drains.
// Reset clears the sequencer and rsp_tvalid and sets entries_in_use to 1.
// Ring memory contents are not cleared: look up only over written entries.
module hash_ring_successor_lookup #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // entry_index[7:0], entry_label[39:8], key_hash[71:40]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // ring_position[7:0], server_id[24:8], zero[31:25]
   output logic        rsp_tuser,   // was_lookup
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata    // entries_in_use
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = (AW + 1 > hrsl_pkg::CFG_WIDTH) ? AW + 1 : hrsl_pkg::CFG_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MIX1, ST_MIX2, ST_CMP, ST_STEP,
      ST_FETCH, ST_MODQ, ST_MODR, ST_MODFIX, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [8:0]  count_ff;
   logic [PW-1:0] lo_ff, hi_ff, mid_ff, n_ff, pos_ff;
   logic        first_ff;
   logic [31:0] key_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0] rdata_ff;
   logic [63:0] prod_ff;
   logic [hrsl_pkg::SID_WIDTH-1:0] sid_ff;
   logic        lookup_ff;
   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   logic [31:0] ring_mem [RING_DEPTH];

   logic          req_fire;
   logic [7:0]    req_index;
   logic [31:0]   req_label;
   logic [31:0]   req_key;
   logic [PW-1:0] idx_ext;
   logic [PW-1:0] cnt_ext;
   logic [PW-1:0] n_in;
   logic          mem_we;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_res;
   logic [31:0]   hash_val;
   logic [PW-1:0] mid_in;
   logic [26:0]   rem_raw;
   logic [26:0]   rem_fix;
   logic          out_free;
   logic          rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_index  = req_tdata[7:0];
   assign req_label  = req_tdata[39:8];
   assign req_key    = req_tdata[71:40];

   assign idx_ext = PW'(req_index);
   assign cnt_ext = PW'(count_ff);
   assign mem_we  = req_fire && (req_tuser == hrsl_pkg::CMD_WRITE)
                    && (idx_ext < PW'(RING_DEPTH));

   always_comb begin
      if (cnt_ext == '0) begin
         n_in = PW'(1);
      end else if (cnt_ext > PW'(RING_DEPTH)) begin
         n_in = PW'(RING_DEPTH);
      end else begin
         n_in = cnt_ext;
      end
   end

   always_comb begin
      case (state_ff)
         ST_MIX1: begin
            mul_a = hrsl_pkg::xor_shift(rdata_ff);
            mul_b = hrsl_pkg::MIX_MULT;
         end
         ST_MIX2: begin
            mul_a = hrsl_pkg::xor_shift(prod_ff[31:0]);
            mul_b = hrsl_pkg::MIX_MULT;
         end
         ST_MODQ: begin
            mul_a = 32'(rdata_ff[31:hrsl_pkg::ID_LOW_BITS]);
            mul_b = hrsl_pkg::ID_RECIP;
         end
         ST_MODR: begin
            mul_a = prod_ff[63:32];
            mul_b = hrsl_pkg::ID_DIVISOR;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res  = {32'd0, mul_a} * {32'd0, mul_b};
   assign hash_val = hrsl_pkg::xor_shift(prod_ff[31:0]);
   assign mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rem_raw  = rdata_ff[31:hrsl_pkg::ID_LOW_BITS] - prod_ff[26:0];
   assign rem_fix  = (rem_raw >= 27'(hrsl_pkg::ID_DIVISOR))
                     ? rem_raw - 27'(hrsl_pkg::ID_DIVISOR) : rem_raw;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = (state_ff == ST_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[idx_ext[AW-1:0]] <= req_label;
      end
      rdata_ff <= ring_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= 9'd1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            count_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         prod_ff <= mul_res;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == hrsl_pkg::CMD_WRITE) begin
                     pos_ff    <= idx_ext;
                     sid_ff    <= '0;
                     lookup_ff <= 1'b0;
                     state_ff  <= ST_DONE;
                  end else begin
                     key_ff   <= req_key;
                     n_ff     <= n_in;
                     first_ff <= 1'b1;
                     addr_ff  <= '0;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ:  state_ff <= ST_MIX1;
            ST_MIX1:  state_ff <= ST_MIX2;
            ST_MIX2:  state_ff <= ST_CMP;
            ST_CMP: begin
               if (first_ff) begin
                  first_ff <= 1'b0;
                  if (key_ff <= hash_val) begin
                     pos_ff   <= '0;
                     addr_ff  <= '0;
                     state_ff <= ST_FETCH;
                  end else begin
                     lo_ff    <= PW'(1);
                     hi_ff    <= n_ff;
                     state_ff <= ST_STEP;
                  end
               end else begin
                  if (hash_val < key_ff) begin
                     lo_ff <= mid_ff + PW'(1);
                  end else begin
                     hi_ff <= mid_ff;
                  end
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  addr_ff  <= mid_in[AW-1:0];
                  state_ff <= ST_READ;
               end else if (lo_ff >= n_ff) begin
                  pos_ff   <= '0;
                  addr_ff  <= '0;
                  state_ff <= ST_FETCH;
               end else begin
                  pos_ff   <= lo_ff;
                  addr_ff  <= lo_ff[AW-1:0];
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: state_ff <= ST_MODQ;
            ST_MODQ:  state_ff <= ST_MODR;
            ST_MODR:  state_ff <= ST_MODFIX;
            ST_MODFIX: begin
               sid_ff    <= {rem_fix[11:0], rdata_ff[hrsl_pkg::ID_LOW_BITS-1:0]};
               lookup_ff <= 1'b1;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_tdata_ff  <= {7'd0, sid_ff, pos_ff[hrsl_pkg::POS_WIDTH-1:0]};
                  rsp_tuser_ff  <= lookup_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
